>>> rtl/stnm_pkg.sv
package stnm_pkg;

   localparam int LaneCount        = 4;
   localparam int MaxEntries       = 4096;
   localparam int CountWidth       = 13;
   localparam int RefWidth         = 16;
   localparam int LevelWidth       = 8;
   localparam int ValidCountWidth  = 3;
   localparam int DivWidth         = 16;
   localparam int HoldWidth        = 4;
   localparam int HoldCounterWidth = 8;
   localparam int ScaledWidth      = RefWidth + 8;
   localparam int ProductWidth     = LevelWidth + DivWidth + 1;
   localparam int TargetFloor      = 9;
   localparam int RatioNum         = 7;
   localparam int RatioDen         = 10;
   localparam int RatioWidth       = CountWidth + 4;
   localparam int HoldMax          = 255;
   localparam int CsrIndexWidth    = 1;

   localparam logic [CsrIndexWidth-1:0] CsrLevelDivisor = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrHoldCount    = 1'b1;

   localparam logic [DivWidth-1:0]  LevelDivisorReset = 16'd256;
   localparam logic [HoldWidth-1:0] HoldCountReset    = 4'd7;

   // per-entry findings handed from the lane stage to the merge stage
   typedef struct packed {
      logic                 below_target;
      logic [LaneCount-1:0] lane_hit;
      logic                 last;
   } stage_result_type;

endpackage

>>> rtl/stnm_lane.sv
module stnm_lane
   import stnm_pkg::*;
(
   input  logic                          clock,
   input  logic                          load,
   input  logic signed [LevelWidth-1:0]  level,
   input  logic                          level_valid,
   input  logic [DivWidth-1:0]           divisor,
   input  logic [ScaledWidth-1:0]        scaled_ref,
   output logic                          hit_ff
);

   logic signed [ProductWidth-1:0] product;
   logic signed [ProductWidth-1:0] scaled_signed;
   logic                           hit_in;

   // level * div > ref * 256, exact in signed integers
   assign product       = level * $signed({1'b0, divisor});
   assign scaled_signed = $signed({1'b0, scaled_ref});
   assign hit_in        = level_valid && (divisor != '0) && (product > scaled_signed);

   always_ff @(posedge clock) begin
      if (load) begin
         hit_ff <= hit_in;
      end
   end

endmodule

>>> rtl/stnm_merge.sv
module stnm_merge
   import stnm_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  stage_result_type             in_result,
   output logic                         in_ready,
   input  logic [HoldWidth-1:0]         hold_count,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [CountWidth-1:0]        rsp_matched_count,
   output logic [CountWidth-1:0]        rsp_entry_count,
   output logic                         rsp_ratio_met,
   output logic                         rsp_report
);

   logic [CountWidth-1:0]       match_ff, match_in;
   logic [CountWidth-1:0]       entry_ff, entry_in;
   logic                        started_ff, started_in;
   logic [HoldCounterWidth-1:0] hold_ff, hold_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [CountWidth-1:0]       matched_ff, entries_ff;
   logic                        met_ff, report_ff;
   logic                        take;
   logic                        hit;
   logic [CountWidth-1:0]       match_next, entry_next;
   logic                        met;
   logic                        report;
   logic [HoldCounterWidth-1:0] hold_inc;

   // a frame end waits only while the result register is still occupied
   assign in_ready = !(in_result.last && rsp_valid_ff && !rsp_ready);
   assign take     = in_valid && in_ready;
   assign hit      = in_result.below_target || (|in_result.lane_hit);

   always_comb begin
      entry_next = (entry_ff < CountWidth'(MaxEntries)) ? entry_ff + 1'b1 : entry_ff;
      match_next = (hit && (match_ff < CountWidth'(MaxEntries))) ? match_ff + 1'b1 : match_ff;
      met = (RatioWidth'(match_next) * RatioWidth'(RatioDen)) >=
            (RatioWidth'(entry_next) * RatioWidth'(RatioNum));
      hold_inc = (hold_ff < HoldCounterWidth'(HoldMax)) ? hold_ff + 1'b1 : hold_ff;

      started_in = started_ff;
      hold_in    = hold_ff;
      report     = 1'b0;
      if (met) begin
         started_in = 1'b1;
         hold_in    = hold_inc;
         report     = hold_inc >= HoldCounterWidth'(hold_count);
      end else if (started_ff) begin
         started_in = 1'b0;
         report     = 1'b1;
      end else begin
         hold_in = '0;
      end

      match_in = match_ff;
      entry_in = entry_ff;
      if (take) begin
         match_in = in_result.last ? '0 : match_next;
         entry_in = in_result.last ? '0 : entry_next;
      end

      if (take && in_result.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff     <= '0;
         entry_ff     <= '0;
         started_ff   <= 1'b0;
         hold_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         match_ff     <= match_in;
         entry_ff     <= entry_in;
         rsp_valid_ff <= rsp_valid_in;
         if (take && in_result.last) begin
            started_ff <= started_in;
            hold_ff    <= hold_in;
         end
      end
      if (take && in_result.last) begin
         matched_ff <= match_next;
         entries_ff <= entry_next;
         met_ff     <= met;
         report_ff  <= report;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matched_count = matched_ff;
   assign rsp_entry_count   = entries_ff;
   assign rsp_ratio_met     = met_ff;
   assign rsp_report        = report_ff;

endmodule

>>> rtl/spectral_template_note_matcher.sv
// the result of a frame is registered after its last entry passes stage 1 and stage 2
// throughput: one request per cycle, sustained; a frame end stalls only while the
//    previous result is still unclaimed at the output register
// reset: synchronous, active high; clears counts, hold state and valids,
//    level_divisor returns to 256 and hold_count to 7; no request or write is taken in reset
module spectral_template_note_matcher
   import stnm_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [RefWidth-1:0]               req_reference_level,
   input  logic signed [LevelWidth-1:0]      req_level_a,
   input  logic signed [LevelWidth-1:0]      req_level_b,
   input  logic signed [LevelWidth-1:0]      req_level_c,
   input  logic signed [LevelWidth-1:0]      req_level_d,
   input  logic [ValidCountWidth-1:0]        req_level_valid_count,
   input  logic                              req_last_entry,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [CountWidth-1:0]             rsp_matched_count,
   output logic [CountWidth-1:0]             rsp_entry_count,
   output logic                              rsp_ratio_met,
   output logic                              rsp_report,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [CsrIndexWidth-1:0]          csr_index,
   input  logic [DivWidth-1:0]               csr_data
);

   // configuration registers
   logic [DivWidth-1:0]  level_divisor_ff;
   logic [HoldWidth-1:0] hold_count_ff;

   // stage 1: captured request
   logic                               s1_valid_ff, s1_valid_in;
   logic [RefWidth-1:0]                s1_ref_ff;
   logic signed [LevelWidth-1:0]       s1_level_ff [LaneCount];
   logic [ValidCountWidth-1:0]         s1_count_ff;
   logic                               s1_last_ff;

   // stage 2: lane findings
   logic                               s2_valid_ff, s2_valid_in;
   logic                               s2_below_ff;
   logic                               s2_last_ff;
   logic [LaneCount-1:0]               lane_hit;
   stage_result_type                   s2_result;

   logic                               req_take;
   logic                               s1_go, s2_go, s2_free;
   logic                               merge_ready;
   logic [ScaledWidth-1:0]             scaled_ref;
   logic [ScaledWidth-1:0]             floor_level;
   logic                               below_target;

   // register writes are taken whenever out of reset
   assign csr_ready = !reset;

   // elastic handshake: each stage moves when the next has room
   assign s2_go     = s2_valid_ff && merge_ready;
   assign s2_free   = !s2_valid_ff || s2_go;
   assign s1_go     = s1_valid_ff && s2_free;
   assign req_ready = !reset && (!s1_valid_ff || s1_go);
   assign req_take  = req_valid && req_ready;

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_go) begin
         s2_valid_in = 1'b1;
      end else if (s2_go) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   // target below floor: ref * 256 < 9 * div, with a zero divisor never matching
   assign scaled_ref   = {s1_ref_ff, 8'd0};
   assign floor_level  = ScaledWidth'(level_divisor_ff) * ScaledWidth'(TargetFloor);
   assign below_target = (level_divisor_ff != '0) && (scaled_ref < floor_level);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_divisor_ff <= LevelDivisorReset;
         hold_count_ff    <= HoldCountReset;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CsrLevelDivisor: level_divisor_ff <= csr_data;
               CsrHoldCount:    hold_count_ff    <= csr_data[HoldWidth-1:0];
               default:         ;
            endcase
         end
      end
      if (req_take) begin
         s1_ref_ff      <= req_reference_level;
         s1_level_ff[0] <= req_level_a;
         s1_level_ff[1] <= req_level_b;
         s1_level_ff[2] <= req_level_c;
         s1_level_ff[3] <= req_level_d;
         s1_count_ff    <= req_level_valid_count;
         s1_last_ff     <= req_last_entry;
      end
      if (s1_go) begin
         s2_below_ff <= below_target;
         s2_last_ff  <= s1_last_ff;
      end
   end

   // one comparator lane per measured level; counts of four and above enable every lane
   for (genvar i = 0; i < LaneCount; i++) begin : g_lane
      stnm_lane u_lane (
         .clock       (clock),
         .load        (s1_go),
         .level       (s1_level_ff[i]),
         .level_valid (s1_count_ff > ValidCountWidth'(i)),
         .divisor     (level_divisor_ff),
         .scaled_ref  (scaled_ref),
         .hit_ff      (lane_hit[i])
      );
   end

   assign s2_result.below_target = s2_below_ff;
   assign s2_result.lane_hit     = lane_hit;
   assign s2_result.last         = s2_last_ff;

   // merge: or the lanes, count the frame, hold qualifier, result register
   stnm_merge u_merge (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (s2_valid_ff),
      .in_result         (s2_result),
      .in_ready          (merge_ready),
      .hold_count        (hold_count_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_matched_count (rsp_matched_count),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_ratio_met     (rsp_ratio_met),
      .rsp_report        (rsp_report)
   );

endmodule
